>>> rtl/crsb_pkg.sv
package crsb_pkg;

    // parse phase codes
    localparam logic [2:0] PH_CNT_LO = 3'd0;
    localparam logic [2:0] PH_CNT_HI = 3'd1;
    localparam logic [2:0] PH_SKP_LO = 3'd2;
    localparam logic [2:0] PH_SKP_HI = 3'd3;
    localparam logic [2:0] PH_OPQ_LO = 3'd4;
    localparam logic [2:0] PH_OPQ_HI = 3'd5;
    localparam logic [2:0] PH_COLOUR = 3'd6;

    // pen offset saturation limit
    localparam logic [19:0] PEN_MAX = 20'hFFFFF;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_SPRITE_ROWS = 3'd2;
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd3;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd4;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd5;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd6;

    // input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       sprite_start;
    } t_blit_in;

    // output transfer payload
    typedef struct packed {
        logic        write_enable;
        logic [14:0] pixel_x;
        logic [14:0] pixel_y;
        logic [7:0]  pixel_color;
        logic        sprite_done;
        logic        byte_ignored;
    } t_blit_out;

endpackage

>>> rtl/clipped_rle_sprite_blitter_core.sv
// result: each input transfer writes its result into the output register
// throughput: one byte per cycle, set by the single parse step between the input
//   handshake and the output register; ready follows the output register's state
// reset: synchronous active-low i_rst_n clears the parse state and the output valid,
//   and loads the register reset values (clip_right and clip_bottom at 32767)
module clipped_rle_sprite_blitter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  crsb_pkg::t_blit_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output crsb_pkg::t_blit_out  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import crsb_pkg::*;

    // configuration registers
    logic [15:0] r_origin_x, r_origin_y;
    logic [14:0] r_sprite_rows, r_clip_left, r_clip_top, r_clip_right, r_clip_bottom;

    // parse state
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_runs, n_runs;
    logic [15:0] r_colour, n_colour;
    logic [19:0] r_pen, n_pen;
    logic [15:0] r_row, n_row;
    logic        r_finished, n_finished;

    // state seen by this byte after a sprite start
    logic [2:0]  cur_phase;
    logic [7:0]  cur_low;
    logic [15:0] cur_runs, cur_colour, cur_row;
    logic [19:0] cur_pen;
    logic        cur_finished;

    logic [15:0] word;
    logic [21:0] px;
    logic [17:0] py;
    logic        run_end, row_end, in_window;
    logic        in_xfer;

    logic        r_out_valid;
    t_blit_out   r_out, n_out;

    // saturating pen advance
    function automatic logic [19:0] pen_add(input logic [19:0] p, input logic [15:0] d);
        logic [20:0] s;
        s = {1'b0, p} + {5'b0, d};
        return s[20] ? PEN_MAX : s[19:0];
    endfunction

    assign pready     = 1'b1;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_sprite_rows <= '0;
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= 15'h7FFF;
            r_clip_bottom <= 15'h7FFF;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                REG_ORIGIN_X:    r_origin_x    <= pwdata[15:0];
                REG_ORIGIN_Y:    r_origin_y    <= pwdata[15:0];
                REG_SPRITE_ROWS: r_sprite_rows <= pwdata[14:0];
                REG_CLIP_LEFT:   r_clip_left   <= pwdata[14:0];
                REG_CLIP_TOP:    r_clip_top    <= pwdata[14:0];
                REG_CLIP_RIGHT:  r_clip_right  <= pwdata[14:0];
                REG_CLIP_BOTTOM: r_clip_bottom <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (paddr[4:2])
            REG_ORIGIN_X:    prdata = {16'b0, r_origin_x};
            REG_ORIGIN_Y:    prdata = {16'b0, r_origin_y};
            REG_SPRITE_ROWS: prdata = {17'b0, r_sprite_rows};
            REG_CLIP_LEFT:   prdata = {17'b0, r_clip_left};
            REG_CLIP_TOP:    prdata = {17'b0, r_clip_top};
            REG_CLIP_RIGHT:  prdata = {17'b0, r_clip_right};
            REG_CLIP_BOTTOM: prdata = {17'b0, r_clip_bottom};
            default:         prdata = '0;
        endcase
    end

    // one parse step per byte
    always_comb begin
        cur_phase    = i_in_data.sprite_start ? PH_CNT_LO : r_phase;
        cur_low      = i_in_data.sprite_start ? 8'd0 : r_low;
        cur_runs     = i_in_data.sprite_start ? 16'd0 : r_runs;
        cur_colour   = i_in_data.sprite_start ? 16'd0 : r_colour;
        cur_pen      = i_in_data.sprite_start ? 20'd0 : r_pen;
        cur_row      = i_in_data.sprite_start ? 16'd0 : r_row;
        cur_finished = i_in_data.sprite_start ? 1'b0 : r_finished;

        n_phase    = cur_phase;
        n_low      = cur_low;
        n_runs     = cur_runs;
        n_colour   = cur_colour;
        n_pen      = cur_pen;
        n_row      = cur_row;
        n_finished = cur_finished;
        n_out      = '0;
        run_end    = 1'b0;
        row_end    = 1'b0;

        word = {i_in_data.data_byte, cur_low};
        px   = {{6{r_origin_x[15]}}, r_origin_x} + {2'b00, cur_pen};
        py   = {{2{r_origin_y[15]}}, r_origin_y} + {2'b00, cur_row};
        in_window = ($signed(px) >= $signed({7'b0, r_clip_left}))
                 && ($signed(px) <  $signed({7'b0, r_clip_right}))
                 && ($signed(py) >= $signed({3'b0, r_clip_top}))
                 && ($signed(py) <  $signed({3'b0, r_clip_bottom}));

        if (cur_finished || (cur_row >= {1'b0, r_sprite_rows})) begin
            n_finished         = 1'b1;
            n_out.byte_ignored = 1'b1;
        end else begin
            unique case (cur_phase) inside
                PH_CNT_HI: begin
                    n_runs = word;
                    if (word == 16'd0) row_end = 1'b1;
                    else n_phase = PH_SKP_LO;
                end
                PH_SKP_LO, PH_OPQ_LO: begin
                    n_low   = i_in_data.data_byte;
                    n_phase = cur_phase + 3'd1;
                end
                PH_SKP_HI: begin
                    n_pen   = pen_add(cur_pen, word);
                    n_phase = PH_OPQ_LO;
                end
                PH_OPQ_HI: begin
                    n_colour = word;
                    if (word == 16'd0) run_end = 1'b1;
                    else n_phase = PH_COLOUR;
                end
                PH_COLOUR: begin
                    if (in_window) begin
                        n_out.write_enable = 1'b1;
                        n_out.pixel_x      = px[14:0];
                        n_out.pixel_y      = py[14:0];
                        n_out.pixel_color  = i_in_data.data_byte;
                    end
                    n_pen    = pen_add(cur_pen, 16'd1);
                    n_colour = cur_colour - 16'd1;
                    if (n_colour == 16'd0) run_end = 1'b1;
                end
                default: begin
                    n_low   = i_in_data.data_byte;
                    n_phase = PH_CNT_HI;
                end
            endcase

            // end of run: next run or end of row
            if (run_end) begin
                n_runs = cur_runs - 16'd1;
                if (n_runs == 16'd0) row_end = 1'b1;
                else n_phase = PH_SKP_LO;
            end

            // end of row: last row finishes the sprite
            if (row_end) begin
                n_row    = cur_row + 16'd1;
                n_pen    = '0;
                n_runs   = '0;
                n_colour = '0;
                n_phase  = PH_CNT_LO;
                if (n_row >= {1'b0, r_sprite_rows}) begin
                    n_finished        = 1'b1;
                    n_out.sprite_done = 1'b1;
                end
            end
        end
    end

    // parse state update on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CNT_LO;
            r_low      <= '0;
            r_runs     <= '0;
            r_colour   <= '0;
            r_pen      <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
        end else if (in_xfer) begin
            r_phase    <= n_phase;
            r_low      <= n_low;
            r_runs     <= n_runs;
            r_colour   <= n_colour;
            r_pen      <= n_pen;
            r_row      <= n_row;
            r_finished <= n_finished;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_colour_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COLOUR) |-> (r_colour != 16'd0))
        else $error("colour phase with no colour bytes left");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 3'd7)
        else $error("parse phase holds the unused code");

    a_ignored_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.byte_ignored) |-> !r_out.write_enable && !r_out.sprite_done)
        else $error("ignored byte carries a write or done flag");

    a_done_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_out.sprite_done) |=> r_finished)
        else $error("sprite done without finished state");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

>>> sim/clipped_rle_sprite_blitter_core_tb.sv
module clipped_rle_sprite_blitter_core_tb;

    import crsb_pkg::*;

    // register index that decodes to nothing
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 2000;

    // expected pixel writes, worked out byte by byte from a private copy of the parser
    class pixel_predictor;
        // window and placement
        logic signed [15:0] org_x = '0;
        logic signed [15:0] org_y = '0;
        logic [14:0] row_limit = '0;
        logic [14:0] clip_l = '0;
        logic [14:0] clip_t = '0;
        logic [14:0] clip_r = 15'h7FFF;
        logic [14:0] clip_b = 15'h7FFF;
        // parse state
        logic [2:0]  parse_ph = PH_CNT_LO;
        logic [7:0]  lo_latch = '0;
        logic [15:0] runs_todo = '0;
        logic [15:0] colours_todo = '0;
        logic [19:0] pen_off = '0;
        logic [15:0] row_idx = '0;
        bit          sprite_over = 0;
        t_blit_out   pixels_due[$];
        int          faults = 0;
        int          live_items = 0;

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_ORIGIN_X:    org_x = val[15:0];
                REG_ORIGIN_Y:    org_y = val[15:0];
                REG_SPRITE_ROWS: row_limit = val[14:0];
                REG_CLIP_LEFT:   clip_l = val[14:0];
                REG_CLIP_TOP:    clip_t = val[14:0];
                REG_CLIP_RIGHT:  clip_r = val[14:0];
                REG_CLIP_BOTTOM: clip_b = val[14:0];
                default: ;
            endcase
        endfunction

        function logic [19:0] pen_sum(logic [19:0] p, logic [15:0] d);
            logic [20:0] s;
            s = {1'b0, p} + {5'b0, d};
            return (s > {1'b0, PEN_MAX}) ? PEN_MAX : s[19:0];
        endfunction

        // returns 1 when the closed row was the last one
        function bit close_row();
            row_idx = row_idx + 16'd1;
            pen_off = '0;
            runs_todo = '0;
            colours_todo = '0;
            parse_ph = PH_CNT_LO;
            if (row_idx >= row_limit) begin
                sprite_over = 1;
                return 1;
            end
            return 0;
        endfunction

        function bit close_run();
            runs_todo = runs_todo - 16'd1;
            if (runs_todo == 0) return close_row();
            parse_ph = PH_SKP_LO;
            return 0;
        endfunction

        function void take_byte(t_blit_in item);
            t_blit_out   res;
            logic [15:0] word;
            int          px;
            int          py;
            bit          last;
            res = '0;
            last = 0;
            live_items++;
            if (item.sprite_start) begin
                parse_ph = PH_CNT_LO;
                lo_latch = '0;
                runs_todo = '0;
                colours_todo = '0;
                pen_off = '0;
                row_idx = '0;
                sprite_over = 0;
            end
            // bytes past the last row only raise the ignore flag
            if (sprite_over || row_idx >= row_limit) begin
                sprite_over = 1;
                res.byte_ignored = 1'b1;
                pixels_due.push_back(res);
                return;
            end
            word = {item.data_byte, lo_latch};
            case (parse_ph)
                PH_CNT_HI: begin
                    runs_todo = word;
                    if (word == 0) last = close_row();
                    else parse_ph = PH_SKP_LO;
                end
                PH_SKP_LO, PH_OPQ_LO: begin
                    lo_latch = item.data_byte;
                    parse_ph = parse_ph + 3'd1;
                end
                PH_SKP_HI: begin
                    pen_off = pen_sum(pen_off, word);
                    parse_ph = PH_OPQ_LO;
                end
                PH_OPQ_HI: begin
                    colours_todo = word;
                    if (word == 0) last = close_run();
                    else parse_ph = PH_COLOUR;
                end
                PH_COLOUR: begin
                    px = int'(org_x) + int'(pen_off);
                    py = int'(org_y) + int'(row_idx);
                    if (px >= int'(clip_l) && px < int'(clip_r) &&
                        py >= int'(clip_t) && py < int'(clip_b)) begin
                        res.write_enable = 1'b1;
                        res.pixel_x = px[14:0];
                        res.pixel_y = py[14:0];
                        res.pixel_color = item.data_byte;
                    end
                    pen_off = pen_sum(pen_off, 16'd1);
                    colours_todo = colours_todo - 16'd1;
                    if (colours_todo == 0) last = close_run();
                end
                default: begin
                    lo_latch = item.data_byte;
                    parse_ph = PH_CNT_HI;
                end
            endcase
            res.sprite_done = last;
            pixels_due.push_back(res);
        endfunction

        function void report_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                faults++;
                $error("%s: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        function void check_pixel(t_blit_out got);
            t_blit_out want;
            if (pixels_due.size() == 0) begin
                faults++;
                if (faults <= 60) $error("result transfer with no pixel expected");
                return;
            end
            want = pixels_due.pop_front();
            report_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
            report_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
            report_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
            report_field("pixel_color", 32'(want.pixel_color), 32'(got.pixel_color));
            report_field("sprite_done", 32'(want.sprite_done), 32'(got.sprite_done));
            report_field("byte_ignored", 32'(want.byte_ignored), 32'(got.byte_ignored));
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_blit_in    in_data = '0;
    logic        out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        in_ready;
    logic        out_valid;
    t_blit_out   out_data;
    logic [31:0] prdata;
    logic        pready;

    bit          steady = 0;
    t_blit_in    stream_q[$];
    pixel_predictor sb = new;

    clipped_rle_sprite_blitter_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // result side back-pressure
    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 19);
    end

    // check every result transfer
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
    end

    // stop a run in which no transfer happens for too long
    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
            else stall++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // apb write: setup cycle, then access cycle
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // all registers, with junk in the unused upper bits
    task automatic set_window(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [14:0] rows, cl, ct, cr, cb);
        reg_write(REG_ORIGIN_X, {16'($urandom), ox});
        reg_write(REG_ORIGIN_Y, {16'($urandom), oy});
        reg_write(REG_SPRITE_ROWS, {17'($urandom), rows});
        reg_write(REG_CLIP_LEFT, {17'($urandom), cl});
        reg_write(REG_CLIP_TOP, {17'($urandom), ct});
        reg_write(REG_CLIP_RIGHT, {17'($urandom), cr});
        reg_write(REG_CLIP_BOTTOM, {17'($urandom), cb});
        if ($urandom_range(3) == 0) reg_write(REG_SPARE, $urandom);
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_byte(input t_blit_in item);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        sb.take_byte(item);
    endtask

    task automatic put_byte(input logic [7:0] b, input bit start);
        t_blit_in item;
        item.data_byte = b;
        item.sprite_start = start;
        stream_q.push_back(item);
    endtask

    // little-endian 16-bit field
    task automatic put16(input logic [15:0] v);
        put_byte(v[7:0], 1'b0);
        put_byte(v[15:8], 1'b0);
    endtask

    task automatic play_stream();
        foreach (stream_q[i]) send_byte(stream_q[i]);
        stream_q.delete();
    endtask

    // wait until every expected result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // well-formed sprite with random runs; far pushes the pen into saturation
    task automatic encode_sprite(input int n_rows, input int max_runs, input int max_opq,
                                 input bit far);
        int          n_runs;
        int          n_opq;
        logic [15:0] skip;
        for (int r = 0; r < n_rows; r++) begin
            n_runs = far ? $urandom_range(17, 20) : $urandom_range(0, max_runs);
            put16(16'(n_runs));
            for (int k = 0; k < n_runs; k++) begin
                if (far) skip = 16'hFFFF;
                else if ($urandom_range(7) == 0) skip = 16'($urandom);
                else skip = 16'($urandom_range(0, 12));
                n_opq = $urandom_range(0, max_opq);
                put16(skip);
                put16(16'(n_opq));
                repeat (n_opq) put_byte(8'($urandom), 1'b0);
            end
        end
        if (stream_q.size() != 0) stream_q[0].sprite_start = 1'b1;
    endtask

    initial begin
        int          kind;
        int          n_rows;
        int          pno;
        int          base;
        bit          far;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [14:0] rows;
        logic [14:0] cl;
        logic [14:0] ct;
        logic [14:0] cr;
        logic [14:0] cb;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: no rows, so the byte is ignored
        put_byte(8'h5A, 1'b1);
        play_stream();
        drain();

        // directed sprite: clipped run, empty run, empty last row, trailing byte,
        // restart over a far skip, restart again mid-sprite
        set_window(16'hFFFF, 16'd1, 15'd2, 15'd0, 15'd0, 15'd2, 15'h7FFF);
        put_byte(8'h02, 1'b1);
        put_byte(8'h00, 1'b0);
        put16(16'd0);
        put16(16'd3);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h80, 1'b0);
        put16(16'd0);
        put16(16'd0);
        put16(16'd0);
        put_byte(8'h7E, 1'b0);
        put_byte(8'h01, 1'b1);
        put_byte(8'h00, 1'b0);
        put16(16'hFFFF);
        put16(16'd1);
        put_byte(8'hAA, 1'b0);
        put_byte(8'h00, 1'b1);
        play_stream();

        // random phases, each with its own window setting
        base = sb.live_items;
        pno = 0;
        while (sb.live_items - base < RANDOM_ITEMS) begin
            drain();
            steady = (pno % 7 == 3);
            far = 0;
            kind = $urandom_range(0, 9);
            ox = 16'($urandom_range(0, 80) - 20);
            oy = 16'($urandom_range(0, 12) - 4);
            rows = 15'($urandom_range(1, 4));
            cl = 15'($urandom_range(0, 20));
            cr = cl + 15'($urandom_range(1, 60));
            ct = 15'($urandom_range(0, 4));
            cb = ct + 15'($urandom_range(1, 6));
            case (kind)
                5: begin
                    // screen edges
                    case ($urandom_range(0, 3))
                        0: begin ox = 16'h8000; oy = 16'h8000; end
                        1: begin ox = 16'h7FF8; oy = 16'h7FFC; end
                        2: begin ox = 16'h7FFF; oy = 16'h0000; end
                        default: begin ox = 16'h0000; oy = 16'h7FFF; end
                    endcase
                    cl = '0;
                    ct = '0;
                    cr = 15'h7FFF;
                    cb = 15'h7FFF;
                    rows = 15'($urandom_range(1, 3));
                end
                6: begin
                    // window with no area
                    if ($urandom_range(1) == 1) begin
                        cl = $urandom_range(1) ? 15'h7FFF : 15'($urandom_range(0, 40));
                        cr = 15'($urandom_range(0, cl));
                    end else begin
                        ct = 15'($urandom_range(0, 8));
                        cb = 15'($urandom_range(0, ct));
                    end
                end
                7: begin
                    ox = 16'($urandom);
                    oy = 16'($urandom);
                    cl = 15'($urandom);
                    ct = 15'($urandom);
                    cr = 15'($urandom);
                    cb = 15'($urandom);
                    rows = 15'($urandom_range(1, 6));
                end
                8: rows = $urandom_range(1) ? 15'h7FFF : 15'h0000;
                9: begin
                    // pen runs into its limit
                    far = 1;
                    ox = $urandom_range(1) ? 16'h8000 : 16'($urandom);
                    cl = '0;
                    ct = '0;
                    cr = 15'h7FFF;
                    cb = 15'h7FFF;
                    rows = 15'($urandom_range(1, 2));
                end
                default: ;
            endcase
            set_window(ox, oy, rows, cl, ct, cr, cb);

            repeat ($urandom_range(4, 10)) begin
                if (sb.live_items - base >= RANDOM_ITEMS) break;
                if (!far && $urandom_range(9) == 0) begin
                    // noise with stray restarts
                    repeat ($urandom_range(1, 10)) put_byte(8'($urandom), $urandom_range(3) == 0);
                end else begin
                    if (rows == 0 || rows > 8) n_rows = $urandom_range(1, 3);
                    else begin
                        case ($urandom_range(0, 9))
                            0: n_rows = rows + 1;
                            1: n_rows = $urandom_range(1, rows);
                            default: n_rows = rows;
                        endcase
                    end
                    encode_sprite(n_rows, 3, far ? 2 : 6, far);
                    // broken sequences
                    case ($urandom_range(0, 19))
                        0, 1: repeat ($urandom_range(1, 6)) begin
                            if (stream_q.size() > 1) void'(stream_q.pop_back());
                        end
                        2, 3: repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 1'b0);
                        4: stream_q[0].sprite_start = 1'b0;
                        default: ;
                    endcase
                end
                play_stream();
            end
            pno++;
        end
        steady = 0;
        drain();
        repeat (4) @(posedge clk);

        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (sb.pending() != 0) $error("%0d pixel results never arrived", sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
